FILE: rtl/kdaf_pkg.sv
// Shared types and constants for the key debounce / auto-repeat / key FIFO block.
// No dependencies; kdaf_csr, kdaf_scan and the core import this package (kdaf_ram does not).
package kdaf_pkg;

   typedef enum logic [1:0] {
      SCAN_UP       = 2'd0,
      SCAN_DEBOUNCE = 2'd1,
      SCAN_START    = 2'd2,
      SCAN_REPEAT   = 2'd3
   } scan_state_type;

   typedef struct packed {
      logic [7:0] start_delay;
      logic [7:0] repeat_delay;
   } cfg_type;

   localparam int CSR_ADDR_W = 3;

   localparam logic [0:0] REG_START_DELAY  = 1'b0;
   localparam logic [0:0] REG_REPEAT_DELAY = 1'b1;

   localparam logic [7:0] START_DELAY_RST  = 8'd50;
   localparam logic [7:0] REPEAT_DELAY_RST = 8'd10;

   localparam logic [0:0] OP_SCAN = 1'b0;
   localparam logic [0:0] OP_READ = 1'b1;

   localparam logic [7:0] KEY_ONE    = 8'd1;
   localparam logic [7:0] EMPTY_CODE = 8'hFF;
   localparam logic [7:0] SCAN_CODE  = 8'd0;

endpackage

FILE: rtl/kdaf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read data holds while rd_en is low.
module kdaf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/kdaf_csr.sv
// Configuration registers (start and repeat delay) behind an APB-style port.
// Depends on kdaf_pkg for the register indices, reset values and cfg_type.
module kdaf_csr
   import kdaf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [0:0] reg_idx;
   logic       wr_fire;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (reg_idx)
            REG_START_DELAY:  cfg_in.start_delay  = csr_pwdata[7:0];
            REG_REPEAT_DELAY: cfg_in.repeat_delay = csr_pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delay  <= START_DELAY_RST;
         cfg_ff.repeat_delay <= REPEAT_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_START_DELAY:  csr_prdata = {24'd0, cfg_ff.start_delay};
         REG_REPEAT_DELAY: csr_prdata = {24'd0, cfg_ff.repeat_delay};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/kdaf_scan.sv
// Key scanner: up, debounce, start delay and repeat states with their counters.
// Depends on kdaf_pkg; raises push for one cycle on each tick that queues a code.
module kdaf_scan
   import kdaf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    tick,
   input  logic    pressed,
   input  cfg_type cfg,
   output logic    push
);

   scan_state_type state_ff;
   scan_state_type state_in;
   logic [7:0]     start_cnt_ff;
   logic [7:0]     start_cnt_in;
   logic [7:0]     repeat_cnt_ff;
   logic [7:0]     repeat_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SCAN_UP;
         start_cnt_ff  <= 8'd0;
         repeat_cnt_ff <= 8'd0;
      end else begin
         state_ff      <= state_in;
         start_cnt_ff  <= start_cnt_in;
         repeat_cnt_ff <= repeat_cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      start_cnt_in  = start_cnt_ff;
      repeat_cnt_in = repeat_cnt_ff;
      push          = 1'b0;
      if (tick) begin
         unique case (state_ff)
            SCAN_UP: begin
               if (pressed) begin
                  state_in = SCAN_DEBOUNCE;
               end
            end
            SCAN_DEBOUNCE: begin
               if (pressed) begin
                  push         = 1'b1;
                  start_cnt_in = cfg.start_delay;
                  state_in     = SCAN_START;
               end else begin
                  state_in = SCAN_UP;
               end
            end
            SCAN_START: begin
               // a zero count never expires: stay here, queue nothing
               if (!pressed) begin
                  state_in = SCAN_DEBOUNCE;
               end else if (start_cnt_ff != 8'd0) begin
                  start_cnt_in = start_cnt_ff - 8'd1;
                  if (start_cnt_ff == 8'd1) begin
                     push          = 1'b1;
                     repeat_cnt_in = cfg.repeat_delay;
                     state_in      = SCAN_REPEAT;
                  end
               end
            end
            SCAN_REPEAT: begin
               if (!pressed) begin
                  state_in = SCAN_DEBOUNCE;
               end else if (repeat_cnt_ff != 8'd0) begin
                  if (repeat_cnt_ff == 8'd1) begin
                     push          = 1'b1;
                     repeat_cnt_in = cfg.repeat_delay;
                  end else begin
                     repeat_cnt_in = repeat_cnt_ff - 8'd1;
                  end
               end
            end
            default: state_in = SCAN_UP;
         endcase
      end
   end

endmodule

FILE: rtl/key_debounce_autorepeat_fifo_core.sv
// Key debouncer with auto-repeat feeding a ring FIFO of key codes held in a RAM.
// An accepted item goes to the pending stage (with the RAM read), then to the output reg.
// One item per cycle unless the output stalls on rsp_tready; at most one RAM access per item.
// Reset (synchronous): scanner up, counters, pointers and count zero, delays 50 and 10.
// The code RAM is not cleared; only entries written since reset are ever read.
module key_debounce_autorepeat_fifo_core
   import kdaf_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // slave side
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] pin_level, [7:1] zero
   input  logic [0:0]            req_tuser,   // [0] operation
   // master side
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [7:0] key_code, [12:8] pending_count, [13] hit
   output logic [0:0]            rsp_tuser,   // [0] key_valid
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   typedef struct packed {
      logic       pop;
      logic [7:0] code;
      logic [4:0] pending;
      logic       hit;
   } pend_type;

   cfg_type           cfg;
   logic              push;
   logic              accept;
   logic              advance;
   logic              tick;
   logic              is_read;
   logic              pop;
   logic              push_ok;
   logic [7:0]        ram_rd_data;
   logic [CNT_W+4:0]  cnt_ext;

   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              s1_valid_ff, s1_valid_in;
   pend_type          s1_ff, s1_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_code_ff, out_code_in;
   logic              out_kvalid_ff, out_kvalid_in;
   logic [4:0]        out_pend_ff, out_pend_in;
   logic              out_hit_ff, out_hit_in;

   kdaf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kdaf_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .tick    (tick),
      .pressed (!req_tdata[0]),
      .cfg     (cfg),
      .push    (push)
   );

   kdaf_ram #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (wr_ptr_ff),
      .wr_data (KEY_ONE),
      .rd_en   (pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // the pending stage waits for the registered RAM read data; it stalls only behind a full output
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign tick       = accept && (req_tuser == OP_SCAN);
   assign is_read    = accept && (req_tuser == OP_READ);
   assign pop        = is_read && (count_ff != '0);
   assign push_ok    = push && (count_ff != CNT_FULL);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      priority if (pop) begin
         count_in  = count_ff - CNT_W'(1);
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end else if (push_ok) begin
         count_in  = count_ff + CNT_W'(1);
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
   end

   assign cnt_ext = {5'd0, count_in};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (accept) begin
         s1_valid_in   = 1'b1;
         s1_in.pop     = pop;
         s1_in.code    = is_read ? EMPTY_CODE : SCAN_CODE;
         s1_in.pending = cnt_ext[4:0];
         s1_in.hit     = (count_in != '0);
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_code_in   = out_code_ff;
      out_kvalid_in = out_kvalid_ff;
      out_pend_in   = out_pend_ff;
      out_hit_in    = out_hit_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            out_code_in   = s1_ff.pop ? ram_rd_data : s1_ff.code;
            out_kvalid_in = s1_ff.pop;
            out_pend_in   = s1_ff.pending;
            out_hit_in    = s1_ff.hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff         <= s1_in;
      out_code_ff   <= out_code_in;
      out_kvalid_ff <= out_kvalid_in;
      out_pend_ff   <= out_pend_in;
      out_hit_ff    <= out_hit_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_hit_ff, out_pend_ff, out_code_ff};
   assign rsp_tuser  = out_kvalid_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("key FIFO count above depth");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      pop |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not decrement the count");

   a_push_inc: assert property (@(posedge clock) disable iff (reset)
      push_ok |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not increment the count");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_ff))
      else $error("pending item lost while output stalled");

endmodule
